// ===== rtl/dalt_pkg.sv =====
// shared types, constants and helpers for the datagram ack loss tracker
`default_nettype none
package dalt_pkg;

  localparam int unsigned PENDING_DEPTH = 32;
  localparam int unsigned IDX_W = $clog2(PENDING_DEPTH);
  localparam int unsigned CNT_W = $clog2(PENDING_DEPTH + 1);

  localparam logic OP_SEND = 1'b0;
  localparam logic OP_RECV = 1'b1;

  typedef enum logic [2:0] {
    ST_SENT      = 3'd0,
    ST_TOO_BIG   = 3'd1,
    ST_TIMEOUT   = 3'd2,
    ST_ACCEPTED  = 3'd3,
    ST_DISCARDED = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    REG_PROTOCOL   = 2'd0,
    REG_SIZE_LIMIT = 2'd1,
    REG_TIMEOUT    = 2'd2
  } reg_idx_e;

  typedef struct packed {
    logic        operation;
    logic [31:0] tick;
    logic [47:0] time_us;
    logic [15:0] payload_length;
    logic [31:0] protocol;
    logic [15:0] remote_sequence;
    logic [15:0] remote_ack;
    logic [31:0] ack_bits;
  } in_item_t;

  typedef struct packed {
    status_e     status;
    logic [15:0] stamped_sequence;
    logic [15:0] stamped_ack;
    logic [15:0] ping_ms;
    logic [31:0] lost_count;
    logic [31:0] sent_count;
    logic [5:0]  pending_count;
  } out_item_t;

  typedef struct packed {
    logic load;
    logic exec;
    logic scan;
    logic samp;
    logic err;
    logic prod;
    logic acc;
    logic fin;
  } cmd_t;

  typedef struct packed {
    logic scan_req;
    logic scan_done;
    logic found;
  } stat_t;

  // ring index add, both operands below the depth
  function automatic logic [IDX_W-1:0] wrap_add(input logic [IDX_W-1:0] a,
                                                 input logic [IDX_W-1:0] b);
    logic [IDX_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= (IDX_W+1)'(PENDING_DEPTH)) begin
      s = s - (IDX_W+1)'(PENDING_DEPTH);
    end
    return s[IDX_W-1:0];
  endfunction

endpackage
`default_nettype wire

// ===== rtl/dalt_ctrl.sv =====
// controller state machine sequencing exec, list walk and ping update
`default_nettype none
module dalt_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           start_i,
  input  wire dalt_pkg::stat_t stat_i,
  output dalt_pkg::cmd_t      cmd_o,
  output logic                busy_o,
  output logic                done_o
);

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_EXEC = 9'b000000010,
    S_SCAN = 9'b000000100,
    S_SAMP = 9'b000001000,
    S_ERR  = 9'b000010000,
    S_PROD = 9'b000100000,
    S_ACC  = 9'b001000000,
    S_FIN  = 9'b010000000,
    S_DONE = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (start_i) state_d = S_EXEC;
      S_EXEC: state_d = stat_i.scan_req ? S_SCAN : S_FIN;
      S_SCAN: begin
        if (stat_i.scan_done) state_d = stat_i.found ? S_SAMP : S_FIN;
      end
      S_SAMP: state_d = S_ERR;
      S_ERR:  state_d = S_PROD;
      S_PROD: state_d = S_ACC;
      S_ACC:  state_d = S_FIN;
      S_FIN:  state_d = S_DONE;
      S_DONE: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    cmd_o.load = (state_q == S_IDLE) && start_i;
    cmd_o.exec = (state_q == S_EXEC);
    cmd_o.scan = (state_q == S_SCAN);
    cmd_o.samp = (state_q == S_SAMP);
    cmd_o.err  = (state_q == S_ERR);
    cmd_o.prod = (state_q == S_PROD);
    cmd_o.acc  = (state_q == S_ACC);
    cmd_o.fin  = (state_q == S_FIN);
  end

  assign busy_o = (state_q != S_IDLE);
  assign done_o = (state_q == S_DONE);

endmodule
`default_nettype wire

// ===== rtl/dalt_datapath.sv =====
// datapath: config registers, pending ring, counters and ping filter
`default_nettype none
module dalt_datapath (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire dalt_pkg::in_item_t item_i,
  input  wire logic               cfg_we_i,
  input  wire logic [1:0]         cfg_idx_i,
  input  wire logic [31:0]        cfg_data_i,
  input  wire dalt_pkg::cmd_t     cmd_i,
  output dalt_pkg::stat_t         stat_o,
  output dalt_pkg::out_item_t     result_o
);

  localparam int unsigned IW = dalt_pkg::IDX_W;
  localparam int unsigned CW = dalt_pkg::CNT_W;
  localparam logic signed [14:0] GAIN = 15'sd6554;
  localparam logic [23:0] RECIP_125 = 24'd8589935;
  localparam logic [27:0] MS_SAT = 28'd8192000;

  logic [15:0] seq_mem [dalt_pkg::PENDING_DEPTH];
  logic [47:0] stamp_mem [dalt_pkg::PENDING_DEPTH];

  dalt_pkg::in_item_t item_q;
  logic [31:0] proto_q;
  logic [15:0] size_q, tmo_q;
  logic [IW-1:0] head_q;
  logic [CW-1:0] used_q, rd_q, wr_q;
  logic [15:0] next_seq_q, lrs_q;
  logic [31:0] lht_q, lost_q, sent_q;
  logic linked_q, found_q, scan_req_q;
  logic signed [39:0] avg_q;
  logic [47:0] hit_stamp_q;
  logic signed [31:0] sample_q;
  logic signed [40:0] err_q;
  logic signed [54:0] prod_q;
  dalt_pkg::status_e status_q;
  logic [15:0] sseq_q, sack_q, ping_ms_q;

  // exec decode
  logic send_ok, tmo, full, recv_ok, newer;
  logic [31:0] eff_lht, elapsed;
  logic [15:0] eff_seq, eff_lrs, dr;

  always_comb begin
    eff_lht = linked_q ? lht_q : item_q.tick;
    eff_seq = linked_q ? next_seq_q : 16'd0;
    eff_lrs = linked_q ? lrs_q : 16'd0;
    elapsed = item_q.tick - eff_lht;
    send_ok = (item_q.operation == dalt_pkg::OP_SEND) && (item_q.payload_length <= size_q);
    tmo     = elapsed > {16'd0, tmo_q};
    full    = (used_q == CW'(dalt_pkg::PENDING_DEPTH));
    recv_ok = (item_q.payload_length < size_q) && (item_q.protocol == proto_q) && linked_q;
    dr      = item_q.remote_sequence - lrs_q;
    newer   = (dr != 16'd0) && (dr <= 16'h8000);
  end

  // walk decode
  logic scan_done, hit, lost_e, ack_e, keep;
  logic [IW-1:0] pf_addr, wr_addr;
  logic [15:0] e_seq_q, dd;
  logic [47:0] e_stamp_q;
  logic [4:0] bit_idx;

  always_comb begin
    scan_done = (rd_q == used_q);
    pf_addr   = cmd_i.exec ? head_q
                           : dalt_pkg::wrap_add(head_q, rd_q[IW-1:0] + IW'(1));
    wr_addr   = dalt_pkg::wrap_add(head_q, wr_q[IW-1:0]);
    hit       = !found_q && (e_seq_q == item_q.remote_ack);
    dd        = item_q.remote_ack - e_seq_q;
    bit_idx   = 5'(dd[5:0] - 6'd1);
    lost_e    = (dd != 16'd0) && (dd <= 16'h8000) && (dd > 16'd32);
    ack_e     = (dd != 16'd0) && (dd <= 16'd32) && item_q.ack_bits[bit_idx];
    keep      = !hit && !lost_e && !ack_e;
  end

  // ring write port
  logic mem_we;
  logic [IW-1:0] mem_addr;
  logic [15:0] mem_seq;
  logic [47:0] mem_stamp;

  always_comb begin
    if (cmd_i.exec) begin
      mem_we    = send_ok && !tmo;
      mem_addr  = full ? head_q : dalt_pkg::wrap_add(head_q, used_q[IW-1:0]);
      mem_seq   = eff_seq;
      mem_stamp = item_q.time_us;
    end else begin
      mem_we    = cmd_i.scan && !scan_done && keep;
      mem_addr  = wr_addr;
      mem_seq   = e_seq_q;
      mem_stamp = e_stamp_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      seq_mem[mem_addr]   <= mem_seq;
      stamp_mem[mem_addr] <= mem_stamp;
    end
  end

  // ring read port, one entry ahead of the walk
  always_ff @(posedge clk_i) begin
    e_seq_q   <= seq_mem[pf_addr];
    e_stamp_q <= stamp_mem[pf_addr];
  end

  // ping filter stages
  logic [47:0] diff;
  logic signed [31:0] sample_d;
  logic signed [40:0] err_d, sum;
  logic signed [54:0] prod_d;
  logic signed [39:0] avg_d;

  always_comb begin
    diff = item_q.time_us - hit_stamp_q;
    if (!diff[47] && (diff[46:31] != 16'd0)) begin
      sample_d = 32'sh7fffffff;
    end else if (diff[47] && (diff[46:31] != 16'hffff)) begin
      sample_d = 32'sh80000000;
    end else begin
      sample_d = diff[31:0];
    end
    err_d  = {{1{sample_q[31]}}, sample_q, 8'd0} - {avg_q[39], avg_q};
    prod_d = err_q * GAIN;
    sum    = {avg_q[39], avg_q} + {{2{prod_q[54]}}, prod_q[54:16]};
    if (sum[40] != sum[39]) begin
      avg_d = sum[40] ? {1'b1, 39'd0} : {1'b0, {39{1'b1}}};
    end else begin
      avg_d = sum[39:0];
    end
  end

  // ms readout: avg / 256000 = (avg >> 11) / 125
  logic [27:0] ms_x;
  logic [46:0] ms_prod;
  logic [15:0] ms_d;

  always_comb begin
    ms_x    = avg_q[38:11];
    ms_prod = {24'd0, ms_x[22:0]} * {23'd0, RECIP_125};
    if (avg_q[39]) begin
      ms_d = 16'd0;
    end else if (ms_x >= MS_SAT) begin
      ms_d = 16'hffff;
    end else begin
      ms_d = ms_prod[45:30];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) item_q <= item_i;
    if (cmd_i.samp) sample_q <= sample_d;
    if (cmd_i.err) err_q <= err_d;
    if (cmd_i.prod) prod_q <= prod_d;
    if (cmd_i.fin) ping_ms_q <= ms_d;
    if (cmd_i.scan && !scan_done && hit) hit_stamp_q <= e_stamp_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      proto_q    <= 32'd0;
      size_q     <= 16'd1024;
      tmo_q      <= 16'd100;
      head_q     <= '0;
      used_q     <= '0;
      rd_q       <= '0;
      wr_q       <= '0;
      next_seq_q <= 16'd0;
      lrs_q      <= 16'd0;
      lht_q      <= 32'd0;
      lost_q     <= 32'd0;
      sent_q     <= 32'd0;
      linked_q   <= 1'b0;
      found_q    <= 1'b0;
      scan_req_q <= 1'b0;
      avg_q      <= '0;
      status_q   <= dalt_pkg::ST_SENT;
      sseq_q     <= 16'd0;
      sack_q     <= 16'd0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          dalt_pkg::REG_PROTOCOL:   proto_q <= cfg_data_i;
          dalt_pkg::REG_SIZE_LIMIT: size_q  <= cfg_data_i[15:0];
          dalt_pkg::REG_TIMEOUT:    tmo_q   <= cfg_data_i[15:0];
          default: ;
        endcase
      end
      if (cmd_i.exec) begin
        rd_q    <= '0;
        wr_q    <= '0;
        found_q <= 1'b0;
        sseq_q  <= 16'd0;
        sack_q  <= 16'd0;
        if (item_q.operation == dalt_pkg::OP_SEND) begin
          if (!send_ok) begin
            status_q <= dalt_pkg::ST_TOO_BIG;
          end else begin
            lht_q      <= eff_lht;
            lrs_q      <= eff_lrs;
            sseq_q     <= eff_seq;
            sack_q     <= eff_lrs;
            if (tmo) begin
              linked_q   <= 1'b0;
              next_seq_q <= eff_seq;
              status_q   <= dalt_pkg::ST_TIMEOUT;
            end else begin
              linked_q   <= 1'b1;
              next_seq_q <= eff_seq + 16'd1;
              sent_q     <= sent_q + 32'd1;
              status_q   <= dalt_pkg::ST_SENT;
              if (full) begin
                head_q <= dalt_pkg::wrap_add(head_q, IW'(1));
                lost_q <= lost_q + 32'd1;
              end else begin
                used_q <= used_q + CW'(1);
              end
            end
          end
        end else if (!recv_ok) begin
          status_q <= dalt_pkg::ST_DISCARDED;
        end else begin
          lht_q    <= item_q.tick;
          status_q <= newer ? dalt_pkg::ST_ACCEPTED : dalt_pkg::ST_DISCARDED;
        end
      end
      scan_req_q <= cmd_i.exec && (item_q.operation == dalt_pkg::OP_RECV) && recv_ok && newer;
      if (cmd_i.scan) begin
        if (scan_done) begin
          used_q <= wr_q;
          lrs_q  <= item_q.remote_sequence;
        end else begin
          rd_q <= rd_q + CW'(1);
          if (keep) wr_q <= wr_q + CW'(1);
          if (hit) found_q <= 1'b1;
          if (lost_e && !hit) lost_q <= lost_q + 32'd1;
        end
      end
      if (cmd_i.acc) avg_q <= avg_d;
    end
  end

  // scan request is decided during exec, before the register settles
  assign stat_o.scan_req  = scan_req_q | (cmd_i.exec && (item_q.operation == dalt_pkg::OP_RECV)
                                          && recv_ok && newer);
  assign stat_o.scan_done = scan_done;
  assign stat_o.found     = found_q;

  always_comb begin
    result_o.status           = status_q;
    result_o.stamped_sequence = sseq_q;
    result_o.stamped_ack      = sack_q;
    result_o.ping_ms          = ping_ms_q;
    result_o.lost_count       = lost_q;
    result_o.sent_count       = sent_q;
    result_o.pending_count    = 6'(used_q);
  end

endmodule
`default_nettype wire

// ===== rtl/datagram_ack_loss_tracker.sv =====
// top level of the datagram ack loss tracker
//
// channel   signals                          transfer when
// item      start_i, item_i, busy_o          start_i high and busy_o low
// result    done_o, result_o                 done_o high, one cycle
// config    cfg_we_i, cfg_idx_i, cfg_data_i  cfg_we_i high
//
// a send or a discarded receive passes through the exec and fin states, then strobes done_o
// an accepted receive walks the pending list entry by entry in the scan state, then runs
// the ping filter (samp, err, prod, acc) when the acked entry is found, before fin and done
// reset clears all control state; the pending ring needs no clearing
// results cannot be stalled; busy_o stays high until the strobe cycle ends
`default_nettype none
module datagram_ack_loss_tracker (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire dalt_pkg::in_item_t item_i,
  output logic                    busy_o,
  output logic                    done_o,
  output dalt_pkg::out_item_t     result_o,
  input  wire logic               cfg_we_i,
  input  wire logic [1:0]         cfg_idx_i,
  input  wire logic [31:0]        cfg_data_i
);

  dalt_pkg::cmd_t  cmd;
  dalt_pkg::stat_t stat;

  dalt_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .stat_i  (stat),
    .cmd_o   (cmd),
    .busy_o  (busy_o),
    .done_o  (done_o)
  );

  dalt_datapath u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .item_i     (item_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .result_o   (result_o)
  );

  a_done_frees: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !busy_o) else $error("busy after result strobe");

  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o) else $error("transfer did not start work");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (result_o.pending_count <= 6'(dalt_pkg::PENDING_DEPTH)))
    else $error("pending count out of range");

  a_sent_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (result_o.status == dalt_pkg::ST_SENT)) |-> (result_o.pending_count != 6'd0))
    else $error("sent with empty pending list");

endmodule
`default_nettype wire
